@@ sv/strip_speckle_contrast_gated_core_defines.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the strip speckle contrast core
// shared implication forms, one clock and one active-low reset
// ----------------------------------------------------------------------------
`ifndef STRIP_SPECKLE_CONTRAST_GATED_CORE_DEFINES_SVH
`define STRIP_SPECKLE_CONTRAST_GATED_CORE_DEFINES_SVH

// same-cycle implication
`define SSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssc_pkg
// widths, register indexes and unit interface types of the contrast core
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_STRIP   = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int COLS_W      = COL_W + 1;
    localparam int N_W         = $clog2(MAX_STRIP + 1);
    localparam int RIS_W       = $clog2(MAX_STRIP);
    localparam int SUM_W       = SAMPLE_BITS + RIS_W;
    localparam int SQ_W        = 2 * SAMPLE_BITS + RIS_W;
    localparam int ROW_W       = 16;
    localparam int STRIPC_W    = 15;
    localparam int CONTRAST_W  = 16;
    localparam int FRAC_BITS   = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 16;
    localparam int OUT_FIELDS_W = CONTRAST_W + COL_W + STRIPC_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL  = 3'd5;

    // request to the contrast unit
    typedef struct packed {
        logic             start;
        logic [N_W-1:0]   n;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
    } ssc_req_t;

    // reply from the contrast unit
    typedef struct packed {
        logic                  done;
        logic [CONTRAST_W-1:0] c;
    } ssc_rep_t;

endpackage

@@ sv/ssc_ram.sv @@
// ----------------------------------------------------------------------------
// ssc_ram
// simple dual-port memory, one write and one registered read port
// ----------------------------------------------------------------------------
module ssc_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/ssc_contrast.sv @@
// ----------------------------------------------------------------------------
// ssc_contrast
// bit-by-bit search of the largest q4.12 contrast c with
// c*c*(n-1)*s*s <= 2^24*n*(n*q-s*s), one result bit per pass of C_TT..C_CMP
// ----------------------------------------------------------------------------
module ssc_contrast
    import ssc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ssc_req_t req,
    output ssc_rep_t rep
);

    localparam int SS_W   = 2 * SUM_W;
    localparam int NQ_W   = N_W + SQ_W;
    localparam int A_W    = N_W + SS_W;
    localparam int RHS_W  = N_W + NQ_W;
    localparam int B_W    = RHS_W + 2 * FRAC_BITS;
    localparam int TT_W   = 2 * CONTRAST_W;
    localparam int ALO_W  = A_W / 2;
    localparam int AHI_W  = A_W - ALO_W;
    localparam int LO_W   = TT_W + ALO_W;
    localparam int PROD_W = TT_W + A_W;
    localparam int BIT_W  = $clog2(CONTRAST_W);

    typedef enum logic [2:0] {
        C_IDLE, C_SQ, C_PRE, C_RHS, C_TT, C_LO, C_HI, C_CMP
    } cstate_t;

    cstate_t               state_reg;
    logic                  done_reg;
    logic [N_W-1:0]        n_reg;
    logic [SUM_W-1:0]      s_reg;
    logic [SQ_W-1:0]       q_reg;
    logic [SS_W-1:0]       ss_reg;
    logic [NQ_W-1:0]       nq_reg;
    logic [NQ_W-1:0]       diff_reg;
    logic [A_W-1:0]        a_reg;
    logic [B_W-1:0]        b_reg;
    logic [TT_W-1:0]       tt_reg;
    logic [LO_W-1:0]       lo_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [CONTRAST_W-1:0] c_reg;
    logic [BIT_W-1:0]      bit_reg;

    logic [CONTRAST_W-1:0] trial;
    logic [SS_W-1:0]       ss_next;
    logic [NQ_W-1:0]       nq_next;
    logic [A_W-1:0]        a_next;
    logic [RHS_W-1:0]      rhs_next;
    logic [TT_W-1:0]       tt_next;
    logic [LO_W-1:0]       lo_next;
    logic [TT_W+AHI_W-1:0] hi_part;
    logic [PROD_W-1:0]     prod_next;

    // datapath products, each registered in the state that uses it
    always_comb
    begin
        trial     = c_reg | (CONTRAST_W'(1) << bit_reg);
        ss_next   = SS_W'(s_reg) * SS_W'(s_reg);
        nq_next   = NQ_W'(n_reg) * NQ_W'(q_reg);
        a_next    = A_W'(n_reg - N_W'(1)) * A_W'(ss_reg);
        rhs_next  = RHS_W'(n_reg) * RHS_W'(diff_reg);
        tt_next   = TT_W'(trial) * TT_W'(trial);
        lo_next   = LO_W'(tt_reg) * LO_W'(a_reg[ALO_W-1:0]);
        hi_part   = (TT_W+AHI_W)'(tt_reg) * (TT_W+AHI_W)'(a_reg[A_W-1:ALO_W]);
        prod_next = {hi_part, {ALO_W{1'b0}}} + PROD_W'(lo_reg);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (req.start)
                    begin
                        n_reg     <= req.n;
                        s_reg     <= req.sum;
                        q_reg     <= req.sq;
                        c_reg     <= '0;
                        bit_reg   <= BIT_W'(CONTRAST_W - 1);
                        state_reg <= C_SQ;
                    end
                end
                C_SQ:
                begin
                    ss_reg    <= ss_next;
                    nq_reg    <= nq_next;
                    state_reg <= C_PRE;
                end
                C_PRE:
                begin
                    diff_reg  <= (nq_reg > NQ_W'(ss_reg)) ? nq_reg - NQ_W'(ss_reg) : '0;
                    a_reg     <= a_next;
                    state_reg <= C_RHS;
                end
                C_RHS:
                begin
                    b_reg     <= {rhs_next, {(2 * FRAC_BITS){1'b0}}};
                    state_reg <= C_TT;
                end
                C_TT:
                begin
                    tt_reg    <= tt_next;
                    state_reg <= C_LO;
                end
                C_LO:
                begin
                    lo_reg    <= lo_next;
                    state_reg <= C_HI;
                end
                C_HI:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= C_CMP;
                end
                C_CMP:
                begin
                    if (prod_reg <= PROD_W'(b_reg))
                    begin
                        c_reg <= trial;
                    end
                    if (bit_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg - BIT_W'(1);
                        state_reg <= C_TT;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign rep.done = done_reg;
    assign rep.c    = c_reg;

endmodule

@@ sv/strip_speckle_contrast_gated_core.sv @@
// ----------------------------------------------------------------------------
// strip_speckle_contrast_gated_core
// per-column speckle contrast (std over mean) over strips of b-scan rows
// ----------------------------------------------------------------------------
// usage
//   s_axis: one sample word per handshake in row-major order, tuser marks the
//   first sample of a frame. m_axis: one result word per column on the last
//   row of every full strip. cfg: register writes, only while idle.
//   per-column sum and sum of squares live in two memories; a sample inside a
//   strip is a read, then a modify and write back in S_UPD; samples outside
//   any strip are taken without leaving the idle state.
//   on the last row of a strip the result comes from a 16-bit search unit:
//   the sample passes S_UPD, S_LEVEL, S_CALC and S_EMIT before its word
//   is loaded into the output register; a gated out or zero-sum word needs
//   no search and skips S_CALC. the next sample is refused until the
//   current one is handled.
//   one output register holds a finished word; while the receiver stalls,
//   the core keeps taking samples until it has a second result to place.
//   reset clears counters and restores register defaults; the memories need
//   no clearing since each strip overwrites them on its first row.
// ----------------------------------------------------------------------------
`include "strip_speckle_contrast_gated_core_defines.svh"

module strip_speckle_contrast_gated_core
    import ssc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // cfg channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // sample input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [15:0]            s_axis_tdata,  // sample[15:0]
    input  logic                   s_axis_tuser,  // frame_start
    // result output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // contrast, column_index, strip_index
    output logic                   m_axis_tuser   // in_range
);

    typedef enum logic [2:0] {S_IDLE, S_UPD, S_LEVEL, S_CALC, S_EMIT} state_t;

    state_t                state_reg;

    logic [COLS_W-1:0]     columns_reg;
    logic [ROW_W-1:0]      rows_reg;
    logic [N_W-1:0]        strip_size_reg;
    logic [ROW_W-1:0]      row_offset_reg;
    logic [ROW_W-1:0]      min_level_reg;
    logic [ROW_W-1:0]      max_level_reg;

    logic [ROW_W-1:0]      row_count_reg;
    logic [COL_W-1:0]      column_count_reg;
    logic [RIS_W-1:0]      row_in_strip_reg;
    logic [STRIPC_W-1:0]   strip_count_reg;

    logic [COL_W-1:0]      idx_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                  first_reg;
    logic                  last_reg;
    logic [STRIPC_W-1:0]   strip_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic                  ok_reg;
    logic [CONTRAST_W-1:0] res_reg;

    logic                  out_valid_reg;
    logic [CONTRAST_W-1:0] out_contrast_reg;
    logic                  out_in_range_reg;
    logic [COL_W-1:0]      out_col_reg;
    logic [STRIPC_W-1:0]   out_strip_reg;

    logic [SUM_W-1:0]      rd_sum;
    logic [SQ_W-1:0]       rd_sq;

    ssc_req_t              req;
    ssc_rep_t              rep;

    logic                  accept;
    logic [SAMPLE_BITS-1:0] sample_in;
    logic [ROW_W-1:0]      rc_eff;
    logic [COL_W-1:0]      cc_eff;
    logic [RIS_W-1:0]      ris_eff;
    logic [STRIPC_W-1:0]   sc_eff;
    logic [COLS_W-1:0]     cols_eff;
    logic                  size_ok;
    logic [ROW_W-1:0]      span_rows;
    logic [STRIPC_W+N_W:0] strip_end;
    logic                  active;
    logic                  gate;
    logic                  last_col;
    logic                  ris_wrap;
    logic [2*SAMPLE_BITS-1:0] sample_sq;
    logic [SUM_W-1:0]      new_sum;
    logic [SQ_W-1:0]       new_sq;
    logic [ROW_W+N_W-1:0]  low_bound;
    logic [ROW_W+N_W-1:0]  high_bound;
    logic                  level_ok;
    logic                  out_free;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg    <= COLS_W'(1024);
            rows_reg       <= ROW_W'(1024);
            strip_size_reg <= N_W'(8);
            row_offset_reg <= '0;
            min_level_reg  <= '0;
            max_level_reg  <= '1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COLUMNS:    columns_reg    <= cfg_data[COLS_W-1:0];
                REG_ROWS:       rows_reg       <= cfg_data[ROW_W-1:0];
                REG_STRIP_SIZE: strip_size_reg <= cfg_data[N_W-1:0];
                REG_ROW_OFFSET: row_offset_reg <= cfg_data[ROW_W-1:0];
                REG_MIN_LEVEL:  min_level_reg  <= cfg_data[ROW_W-1:0];
                REG_MAX_LEVEL:  max_level_reg  <= cfg_data[ROW_W-1:0];
                default:        ;
            endcase
        end
    end

    // position of the incoming sample and the strip gate
    always_comb
    begin
        accept    = s_axis_tvalid && s_axis_tready;
        sample_in = s_axis_tdata[SAMPLE_BITS-1:0];
        rc_eff    = s_axis_tuser ? '0 : row_count_reg;
        cc_eff    = s_axis_tuser ? '0 : column_count_reg;
        ris_eff   = s_axis_tuser ? '0 : row_in_strip_reg;
        sc_eff    = s_axis_tuser ? '0 : strip_count_reg;
        if (columns_reg == '0)
        begin
            cols_eff = COLS_W'(1);
        end
        else if (columns_reg > COLS_W'(MAX_COLUMNS))
        begin
            cols_eff = COLS_W'(MAX_COLUMNS);
        end
        else
        begin
            cols_eff = columns_reg;
        end
        size_ok   = (strip_size_reg >= N_W'(2)) && (strip_size_reg <= N_W'(MAX_STRIP));
        span_rows = (rows_reg > row_offset_reg) ? rows_reg - row_offset_reg : '0;
        strip_end = (STRIPC_W+N_W+1)'({1'b0, sc_eff} + (STRIPC_W+1)'(1))
                  * (STRIPC_W+N_W+1)'(strip_size_reg);
        active    = rc_eff < rows_reg;
        gate      = active && size_ok
                  && ((ROW_W+1)'(span_rows) >= (ROW_W+1)'({strip_size_reg, 1'b0}))
                  && (rc_eff >= row_offset_reg)
                  && (strip_end <= (STRIPC_W+N_W+1)'(span_rows));
        last_col  = (COLS_W'(cc_eff) + COLS_W'(1)) >= cols_eff;
        ris_wrap  = (N_W'(ris_eff) + N_W'(1)) >= strip_size_reg;
    end

    // read-modify-write of the column stores, level window check and output-free test
    always_comb
    begin
        sample_sq  = sample_reg * sample_reg;
        new_sum    = first_reg ? SUM_W'(sample_reg) : rd_sum + SUM_W'(sample_reg);
        new_sq     = first_reg ? SQ_W'(sample_sq) : rd_sq + SQ_W'(sample_sq);
        low_bound  = (ROW_W+N_W)'(min_level_reg) * (ROW_W+N_W)'(strip_size_reg);
        high_bound = (ROW_W+N_W)'(max_level_reg) * (ROW_W+N_W)'(strip_size_reg);
        level_ok   = ((ROW_W+N_W)'(sum_reg) >= low_bound)
                  && ((ROW_W+N_W)'(sum_reg) <= high_bound);
        out_free   = !out_valid_reg || m_axis_tready;
    end

    ssc_ram #(.WIDTH(SUM_W), .DEPTH(MAX_COLUMNS)) u_sum_ram (
        .clk   (clk),
        .we    (state_reg == S_UPD),
        .waddr (idx_reg),
        .wdata (new_sum),
        .re    (accept),
        .raddr (cc_eff),
        .rdata (rd_sum)
    );

    ssc_ram #(.WIDTH(SQ_W), .DEPTH(MAX_COLUMNS)) u_sq_ram (
        .clk   (clk),
        .we    (state_reg == S_UPD),
        .waddr (idx_reg),
        .wdata (new_sq),
        .re    (accept),
        .raddr (cc_eff),
        .rdata (rd_sq)
    );

    // contrast search unit
    assign req.start = (state_reg == S_LEVEL) && level_ok && (sum_reg != '0);
    assign req.n     = strip_size_reg;
    assign req.sum   = sum_reg;
    assign req.sq    = sq_reg;

    ssc_contrast u_contrast (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rep   (rep)
    );

    // control, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            row_count_reg    <= '0;
            column_count_reg <= '0;
            row_in_strip_reg <= '0;
            strip_count_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // word taken by the receiver; a new one is loaded in S_EMIT
            if (out_valid_reg && m_axis_tready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg    <= cc_eff;
                        sample_reg <= sample_in;
                        first_reg  <= (ris_eff == '0);
                        last_reg   <= ris_wrap;
                        strip_reg  <= sc_eff;
                        if (active && last_col)
                        begin
                            column_count_reg <= '0;
                            row_count_reg    <= rc_eff + ROW_W'(1);
                            if ((rc_eff >= row_offset_reg) && size_ok && ris_wrap)
                            begin
                                row_in_strip_reg <= '0;
                                strip_count_reg  <= (sc_eff != '1) ?
                                                    sc_eff + STRIPC_W'(1) : sc_eff;
                            end
                            else if ((rc_eff >= row_offset_reg) && size_ok)
                            begin
                                row_in_strip_reg <= ris_eff + RIS_W'(1);
                                strip_count_reg  <= sc_eff;
                            end
                            else
                            begin
                                row_in_strip_reg <= ris_eff;
                                strip_count_reg  <= sc_eff;
                            end
                        end
                        else
                        begin
                            column_count_reg <= active ? cc_eff + COL_W'(1) : cc_eff;
                            row_count_reg    <= rc_eff;
                            row_in_strip_reg <= ris_eff;
                            strip_count_reg  <= sc_eff;
                        end
                        if (gate)
                        begin
                            state_reg <= S_UPD;
                        end
                    end
                end
                S_UPD:
                begin
                    sum_reg   <= new_sum;
                    sq_reg    <= new_sq;
                    state_reg <= last_reg ? S_LEVEL : S_IDLE;
                end
                S_LEVEL:
                begin
                    ok_reg  <= level_ok;
                    res_reg <= '0;
                    state_reg <= req.start ? S_CALC : S_EMIT;
                end
                S_CALC:
                begin
                    if (rep.done)
                    begin
                        res_reg   <= rep.c;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_contrast_reg <= res_reg;
                        out_in_range_reg <= ok_reg;
                        out_col_reg      <= idx_reg;
                        out_strip_reg    <= strip_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_in_range_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                            out_strip_reg, out_col_reg, out_contrast_reg};

    // a gated-out result carries zero contrast
    `SSC_ASSERT_NOW(a_zero_when_gated, clk, rst_n,
        m_axis_tvalid && !m_axis_tuser, m_axis_tdata[CONTRAST_W-1:0] == '0)
    // a gated sample goes on to the store update
    `SSC_ASSERT_NEXT(a_gate_to_update, clk, rst_n,
        accept && gate, state_reg == S_UPD)
    // the search unit only finishes while the controller waits for it
    `SSC_ASSERT_NOW(a_done_in_calc, clk, rst_n,
        rep.done, state_reg == S_CALC)

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for strip_speckle_contrast_gated_core
// drives b-scan sample words and register writes, predicts every contrast
// word from its own bit-exact model and checks each one in order
// ----------------------------------------------------------------------------
module testbench;
    import ssc_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 200;
    localparam int MAX_REPORTS = 10;

    // one contrast word as the core should produce it
    typedef struct packed {
        logic [15:0] contrast;
        logic        in_range;
        logic [11:0] column_index;
        logic [14:0] strip_index;
    } contrast_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata = '0;  // sample[15:0]
    logic                   s_axis_tuser = 1'b0; // frame_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;       // contrast, column_index, strip_index
    logic                   m_axis_tuser;       // in_range

    strip_speckle_contrast_gated_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // predictor copy of registers and per-column stores
    logic [12:0] shadow_columns = 13'd1024;
    logic [15:0] shadow_rows = 16'd1024;
    logic [6:0]  shadow_strip = 7'd8;
    logic [15:0] shadow_offset = 16'd0;
    logic [15:0] shadow_min = 16'd0;
    logic [15:0] shadow_max = 16'hFFFF;
    longint unsigned strip_sum [MAX_COLUMNS];
    longint unsigned strip_sq [MAX_COLUMNS];
    longint unsigned row_pos = 0, col_pos = 0, row_of_strip = 0, strip_pos = 0;

    contrast_word_t pending_words[$];
    int unsigned mismatches = 0;
    int unsigned words_checked = 0;
    int unsigned samples_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          calm = 1'b0;

    // largest q4.12 c with c^2 (n-1) s^2 <= 2^24 n (n q - s^2)
    function automatic logic [15:0] contrast_q412(longint unsigned n, longint unsigned s,
                                                  longint unsigned q);
        logic [127:0] ss, nq, diff, rhs, lhs, t;
        logic [15:0]  c;
        ss = 128'(s) * 128'(s);
        nq = 128'(n) * 128'(q);
        diff = (nq > ss) ? nq - ss : 128'd0;
        rhs = (128'(n) * diff) << 24;
        c = '0;
        for (int b = 15; b >= 0; b--)
        begin
            t = 128'(c | (16'd1 << b));
            lhs = t * t * 128'(n - 1) * ss;
            if (lhs <= rhs)
                c = t[15:0];
        end
        return c;
    endfunction

    // advance the predictor by one accepted sample word
    function automatic void predict_sample(logic [15:0] smp, logic fs);
        longint unsigned cols, n, strips, idx, s;
        bit             size_ok, ok;
        contrast_word_t w;
        cols = shadow_columns;
        n = shadow_strip;
        size_ok = (n >= 2 && n <= MAX_STRIP);
        strips = 0;
        if (fs)
        begin
            row_pos = 0;
            col_pos = 0;
            row_of_strip = 0;
            strip_pos = 0;
        end
        if (cols == 0)
            cols = 1;
        if (cols > MAX_COLUMNS)
            cols = MAX_COLUMNS;
        if (size_ok && shadow_rows > shadow_offset)
            strips = (shadow_rows - shadow_offset) / n;
        if (row_pos >= shadow_rows)
            return;
        if (size_ok && strips >= 2 && row_pos >= shadow_offset && strip_pos < strips)
        begin
            idx = col_pos % MAX_COLUMNS;
            if (row_of_strip == 0)
            begin
                strip_sum[idx] = smp;
                strip_sq[idx] = longint'(smp) * longint'(smp);
            end
            else
            begin
                strip_sum[idx] += smp;
                strip_sq[idx] += longint'(smp) * longint'(smp);
            end
            if (row_of_strip + 1 >= n)
            begin
                s = strip_sum[idx];
                ok = (s >= shadow_min * n) && (s <= shadow_max * n);
                w.contrast = (ok && s != 0) ? contrast_q412(n, s, strip_sq[idx]) : 16'd0;
                w.in_range = ok;
                w.column_index = col_pos[11:0];
                w.strip_index = strip_pos[14:0];
                pending_words.push_back(w);
            end
        end
        if (col_pos + 1 >= cols)
        begin
            col_pos = 0;
            if (row_pos >= shadow_offset && size_ok)
            begin
                row_of_strip++;
                if (row_of_strip >= n)
                begin
                    row_of_strip = 0;
                    if (strip_pos < 'h7FFF)
                        strip_pos++;
                end
            end
            row_pos++;
        end
        else
            col_pos++;
    endfunction

    // receiver ready, with random stalls and long hold-offs
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
    end

    // result checking, sampled away from the active edge
    always @(negedge clk)
    begin
        contrast_word_t want, got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.contrast = m_axis_tdata[15:0];
            got.column_index = m_axis_tdata[27:16];
            got.strip_index = m_axis_tdata[42:28];
            got.in_range = m_axis_tuser;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: contrast %0d col %0d strip %0d",
                             got.contrast, got.column_index, got.strip_index);
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected c %0d r %0d col %0d strip %0d",
                                 want.contrast, want.in_range, want.column_index,
                                 want.strip_index);
                        $display("          got      c %0d r %0d col %0d strip %0d",
                                 got.contrast, got.in_range, got.column_index,
                                 got.strip_index);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // write one register while the core is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        bit hs;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            hs = cfg_ready;
            @(posedge clk);
        end
        while (!hs);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_COLUMNS:    shadow_columns = value[12:0];
            REG_ROWS:       shadow_rows = value;
            REG_STRIP_SIZE: shadow_strip = value[6:0];
            REG_ROW_OFFSET: shadow_offset = value;
            REG_MIN_LEVEL:  shadow_min = value;
            REG_MAX_LEVEL:  shadow_max = value;
            default: ;
        endcase
    endtask

    // send one sample word, with a random gap before it
    task automatic send_sample(logic [15:0] smp, logic fs);
        bit hs;
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 15)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        s_axis_tuser <= fs;
        do
        begin
            @(negedge clk);
            hs = s_axis_tready;
            @(posedge clk);
        end
        while (!hs);
        predict_sample(smp, fs);
        samples_sent++;
    endtask

    // stop offering and let every expected word come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_frame(int cols, int rows, int strip, int offset, int lo, int hi);
        drain();
        write_reg(REG_COLUMNS, 16'(cols));
        write_reg(REG_ROWS, 16'(rows));
        write_reg(REG_STRIP_SIZE, 16'(strip));
        write_reg(REG_ROW_OFFSET, 16'(offset));
        write_reg(REG_MIN_LEVEL, 16'(lo));
        write_reg(REG_MAX_LEVEL, 16'(hi));
    endtask

    function automatic logic [15:0] pick_sample;
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            3: return 16'($urandom_range(1000, 1100));
            default: return 16'($urandom);
        endcase
    endfunction

    // a frame of random samples, first word flagged as frame start
    task automatic send_frame(int count);
        for (int i = 0; i < count; i++)
            send_sample(pick_sample(), i == 0);
    endtask

    // extremes, zero sum, flat strip, level gate and frame restart
    task automatic test_directed;
        logic [15:0] vals [10] = '{16'd9, 16'd9, 16'hFFFF, 16'd0, 16'd0, 16'd0,
                                   16'hFFFF, 16'd0, 16'd0, 16'd0};
        set_frame(2, 5, 2, 1, 0, 16'hFFFF);
        for (int i = 0; i < 10; i++)
            send_sample(vals[i], i == 0);
        // window that rejects a bright column
        set_frame(2, 4, 2, 0, 100, 200);
        for (int i = 0; i < 8; i++)
            send_sample((i % 2) ? 16'd150 : 16'd60000, i == 0);
        // frame start in the middle of a strip
        send_sample(16'd5, 1'b1);
        send_sample(16'd7, 1'b1);
        send_sample(16'd300, 1'b0);
    endtask

    // register extremes and the cases that emit nothing
    task automatic test_register_limits;
        set_frame(0, 4, 2, 0, 0, 16'hFFFF);
        send_frame(6);
        set_frame(13'h1FFF, 4, 2, 0, 0, 16'hFFFF);
        send_frame(20);
        set_frame(4096, 2, 2, 0, 0, 16'hFFFF);
        send_frame(10);
        set_frame(1, 16'hFFFF, 64, 0, 0, 16'hFFFF);
        send_frame(140);
        set_frame(2, 16'hFFFF, 64, 16'hFFFF, 0, 16'hFFFF);
        send_frame(20);
        set_frame(2, 6, 0, 0, 0, 16'hFFFF);
        send_frame(12);
        set_frame(2, 6, 1, 0, 0, 16'hFFFF);
        send_frame(12);
        set_frame(2, 200, 127, 0, 0, 16'hFFFF);
        send_frame(12);
        set_frame(2, 5, 3, 0, 0, 16'hFFFF);
        send_frame(12);
        set_frame(3, 1, 2, 0, 0, 16'hFFFF);
        send_frame(6);
        set_frame(2, 6, 2, 0, 16'hFFFF, 16'hFFFF);
        send_frame(12);
        set_frame(2, 6, 2, 0, 16'hFFFF, 0);
        send_frame(12);
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure;
        set_frame(3, 8, 2, 0, 0, 16'hFFFF);
        stall_left = 500;
        calm = 1'b1;
        send_frame(24);
        calm = 1'b0;
        drain();
    endtask

    // random frames, mostly well formed, some noise and overruns
    task automatic test_random;
        int cols, strip, offset, rows, lo, count;
        int unsigned start;
        start = samples_sent;
        while (samples_sent - start < 1250)
        begin
            cols = $urandom_range(1, 6);
            strip = ($urandom_range(0, 15) == 0) ? 64 : $urandom_range(2, 6);
            offset = $urandom_range(0, 3);
            rows = offset + strip * $urandom_range(2, 3) + $urandom_range(0, 2);
            lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0;
            if ($urandom_range(0, 19) == 0)
                strip = $urandom_range(0, 1);
            set_frame(cols, rows, strip, offset, lo,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(lo, 65535) : 65535);
            calm = ($urandom_range(0, 9) == 0);
            count = cols * rows + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0);
            if (strip == 64)
                count = cols * rows;
            for (int i = 0; i < count; i++)
                send_sample(pick_sample(), (i == 0) || ($urandom_range(0, 299) == 0));
            calm = 1'b0;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_limits();
        test_backpressure();
        test_random();
        drain();
        $display("sent %0d sample words, checked %0d contrast words", samples_sent,
                 words_checked);
        $display("covered register extremes, level gating, restarts and stalls");
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
